// ===== rtl/core/ebws_pkg.sv =====
`default_nettype none
package ebws_pkg;
   localparam int TABLE_DEPTH = 1024;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_WIDTH = $clog2(TABLE_DEPTH);
   localparam int SIZE_WIDTH = ADDR_WIDTH + 1;
   localparam int GUESS_WIDTH = 32;
   // index span needs ADDR_WIDTH bits, product span*delta
   localparam int PROD_WIDTH = ADDR_WIDTH + KEY_WIDTH;

   localparam logic [1:0] CSR_WINDOW_HALF = 2'd0;
   localparam logic [1:0] CSR_TABLE_SIZE = 2'd1;
   localparam logic [1:0] CSR_SEARCH_MODE = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic load_key;
      logic start_query;
      logic issue_lo_read;
      logic issue_hi_read;
      logic issue_probe_read;
      logic capture_lo;
      logic capture_hi;
      logic start_div;
      logic compare_probe;
   } ebws_cmd_type;

   typedef struct packed {
      logic window_empty;
      logic mode_interp;
      logic range_empty;
      logic single_entry;
      logic outside_keys;
      logic keys_equal;
      logic div_done;
      logic probe_hit;
   } ebws_status_type;
endpackage
`default_nettype wire

// ===== rtl/core/ebws_divider.sv =====
`default_nettype none
module ebws_divider (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [ebws_pkg::PROD_WIDTH-1:0] dividend,
   input  wire logic [ebws_pkg::KEY_WIDTH-1:0] divisor,
   output logic done,
   output logic [ebws_pkg::PROD_WIDTH-1:0] quotient
);
   localparam int CW = $clog2(ebws_pkg::PROD_WIDTH + 1);
   logic [CW-1:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic [ebws_pkg::PROD_WIDTH-1:0] quot_ff, quot_in;
   logic [ebws_pkg::KEY_WIDTH:0] rem_ff, rem_in;
   logic [ebws_pkg::KEY_WIDTH-1:0] div_ff, div_in;
   logic done_ff, done_in;
   logic [ebws_pkg::KEY_WIDTH:0] trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      count_in = count_ff;
      busy_in = busy_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      done_in = 1'b0;
      trial = {rem_ff[ebws_pkg::KEY_WIDTH-1:0], quot_ff[ebws_pkg::PROD_WIDTH-1]};
      if (start) begin
         busy_in = 1'b1;
         count_in = CW'(ebws_pkg::PROD_WIDTH);
         quot_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quot_in = {quot_ff[ebws_pkg::PROD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[ebws_pkg::PROD_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

// ===== rtl/core/ebws_datapath.sv =====
`default_nettype none
module ebws_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ebws_pkg::ebws_cmd_type cmd,
   input  wire logic [ebws_pkg::ADDR_WIDTH-1:0] load_address,
   input  wire logic [31:0] value,
   input  wire logic [ebws_pkg::GUESS_WIDTH-1:0] guess_position,
   input  wire logic [10:0] window_half,
   input  wire logic [10:0] table_size,
   input  wire logic search_mode,
   output ebws_pkg::ebws_status_type status,
   output logic [ebws_pkg::ADDR_WIDTH-1:0] hit_position
);
   localparam int AW = ebws_pkg::ADDR_WIDTH;
   localparam int KW = ebws_pkg::KEY_WIDTH;
   localparam int WW = ebws_pkg::GUESS_WIDTH + 2;

   logic [KW-1:0] key_mem [ebws_pkg::TABLE_DEPTH];
   logic [KW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;

   // bounds held two bits wider, signed, so hi = -1 and lo = last+1 are representable
   logic signed [AW+1:0] lo_ff, lo_in, hi_ff, hi_in, probe_ff, probe_in;
   logic [KW-1:0] target_ff, klo_ff, khi_ff, kprobe;
   logic mode_ff;
   logic empty_ff;
   logic [ebws_pkg::PROD_WIDTH-1:0] quotient, dividend;
   logic div_done;

   logic signed [WW-1:0] guess_ext, wlo, whi, last_ext;
   logic [ebws_pkg::SIZE_WIDTH-1:0] size_sat;

   always_comb begin
      size_sat = (table_size > 11'(ebws_pkg::TABLE_DEPTH))
         ? ebws_pkg::SIZE_WIDTH'(ebws_pkg::TABLE_DEPTH) : ebws_pkg::SIZE_WIDTH'(table_size);
      guess_ext = WW'(signed'(guess_position));
      last_ext = WW'(size_sat) - WW'(1);
      wlo = guess_ext - WW'(window_half);
      whi = guess_ext + WW'(window_half);
      if (wlo < 0) wlo = '0;
      if (whi > last_ext) whi = last_ext;
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      probe_in = probe_ff;
      if (cmd.start_query) begin
         lo_in = (AW+2)'(wlo);
         hi_in = (AW+2)'(whi);
      end
      if (cmd.issue_probe_read) begin
         if (!mode_ff)
            probe_in = lo_ff + ((hi_ff - lo_ff) >>> 1);
         else if (klo_ff == khi_ff)
            probe_in = lo_ff;
         else
            probe_in = lo_ff + (AW+2)'(quotient);
      end
      if (cmd.compare_probe && kprobe != target_ff) begin
         if (kprobe < target_ff) lo_in = probe_ff + (AW+2)'(1);
         else hi_in = probe_ff - (AW+2)'(1);
      end
   end

   assign kprobe = rd_data_ff;

   always_comb begin
      priority if (cmd.issue_lo_read) rd_addr = AW'(lo_ff);
      else if (cmd.issue_hi_read) rd_addr = AW'(hi_ff);
      else rd_addr = AW'(probe_in);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) key_mem[load_address] <= value[KW-1:0];
      rd_data_ff <= key_mem[rd_addr];
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      probe_ff <= probe_in;
      if (cmd.start_query) begin
         target_ff <= value[KW-1:0];
         mode_ff <= search_mode;
         // window decided once, input fields may change after the handshake
         empty_ff <= (size_sat == '0) || (wlo > whi);
      end
      if (cmd.capture_lo) klo_ff <= rd_data_ff;
      if (cmd.capture_hi) khi_ff <= rd_data_ff;
   end

   assign dividend = ebws_pkg::PROD_WIDTH'(AW'(hi_ff - lo_ff))
      * ebws_pkg::PROD_WIDTH'(target_ff - klo_ff);

   ebws_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.start_div),
      .dividend(dividend), .divisor(khi_ff - klo_ff),
      .done(div_done), .quotient(quotient)
   );

   assign status.window_empty = empty_ff;
   assign status.mode_interp = mode_ff;
   assign status.range_empty = lo_ff > hi_ff;
   assign status.single_entry = lo_ff == hi_ff;
   assign status.outside_keys = (target_ff < klo_ff) || (target_ff > khi_ff);
   assign status.keys_equal = klo_ff == khi_ff;
   assign status.div_done = div_done;
   assign status.probe_hit = kprobe == target_ff;
   assign hit_position = AW'(probe_ff);
endmodule
`default_nettype wire

// ===== rtl/core/ebws_control.sv =====
`default_nettype none
module ebws_control (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic req_cmd,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic rsp_found,
   input  wire ebws_pkg::ebws_status_type status,
   output ebws_pkg::ebws_cmd_type cmd,
   output logic take_position
);
   localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_RDLO = 4'd2, S_RDHI = 4'd3,
      S_TEST = 4'd5, S_WAITDIV = 4'd7, S_CMP = 4'd9, S_DONE = 4'd10;
   logic [3:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in, found_ff, found_in;
   logic accept;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in = found_ff;
      cmd = '0;
      take_position = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == ebws_pkg::CMD_LOAD) cmd.load_key = 1'b1;
               else begin
                  cmd.start_query = 1'b1;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (status.window_empty || status.range_empty) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else if (status.mode_interp) begin
               cmd.issue_lo_read = 1'b1;
               state_in = S_RDLO;
            end else begin
               cmd.issue_probe_read = 1'b1;
               state_in = S_CMP;
            end
         end
         S_RDLO: begin
            cmd.capture_lo = 1'b1;
            cmd.issue_hi_read = 1'b1;
            state_in = S_RDHI;
         end
         S_RDHI: begin
            cmd.capture_hi = 1'b1;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (status.outside_keys) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else if (status.single_entry) begin
               // single entry inside bounds means klo equals target
               cmd.issue_probe_read = 1'b1;
               state_in = S_CMP;
            end else if (status.keys_equal) begin
               cmd.issue_probe_read = 1'b1;
               state_in = S_CMP;
            end else begin
               cmd.start_div = 1'b1;
               state_in = S_WAITDIV;
            end
         end
         S_WAITDIV: begin
            if (status.div_done) begin
               cmd.issue_probe_read = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare_probe = 1'b1;
            if (status.probe_hit) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else state_in = S_CHECK;
         end
         S_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               take_position = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff <= found_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_found = found_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("accept while busy");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_DONE) else $error("stray response");
   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_key, cmd.start_query, cmd.start_div})) else $error("cmd clash");
endmodule
`default_nettype wire

// ===== rtl/core/error_bounded_window_search_core.sv =====
`default_nettype none
// sequence: a load writes the key memory and gives no response; a query with an empty window
// goes from CHECK to DONE; otherwise each binary probe passes CHECK and CMP, each
// interpolation probe that divides passes CHECK, RDLO, RDHI, TEST, WAITDIV, CMP (42-bit
// serial divider, one bit a cycle), and one that needs no division skips WAITDIV
// throughput: one transaction at a time, next accepted after the response is taken
// reset: synchronous active high, clears controller and registers; key memory is not cleared
module error_bounded_window_search_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // tdata: address[9:0], value[41:10], guess_position[73:42], zero fill to 80
   input  wire logic [79:0] req_tdata,
   // tuser: cmd
   input  wire logic req_tuser,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata: position[9:0], zero fill
   output logic [15:0] rsp_tdata,
   // tuser: found
   output logic rsp_tuser,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [31:0] csr_data
);
   logic [10:0] window_half_ff, table_size_ff;
   logic search_mode_ff;
   ebws_pkg::ebws_cmd_type cmd;
   ebws_pkg::ebws_status_type status;
   logic [ebws_pkg::ADDR_WIDTH-1:0] hit_position;
   logic [ebws_pkg::ADDR_WIDTH-1:0] position_ff;
   logic take_position, found;

   // register writes always taken
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         window_half_ff <= '0;
         table_size_ff <= '0;
         search_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ebws_pkg::CSR_WINDOW_HALF: window_half_ff <= csr_data[10:0];
            ebws_pkg::CSR_TABLE_SIZE: table_size_ff <= csr_data[10:0];
            ebws_pkg::CSR_SEARCH_MODE: search_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   ebws_control u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_cmd(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_found(found), .status(status), .cmd(cmd), .take_position(take_position)
   );

   ebws_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .load_address(req_tdata[9:0]),
      .value(req_tdata[41:10]), .guess_position(req_tdata[73:42]),
      .window_half(window_half_ff), .table_size(table_size_ff),
      .search_mode(search_mode_ff), .status(status), .hit_position(hit_position)
   );

   // position reported as zero when not found
   always_ff @(posedge clock) begin
      if (take_position) position_ff <= found ? hit_position : '0;
   end

   assign rsp_tdata = {6'd0, position_ff};
   assign rsp_tuser = found;
endmodule
`default_nettype wire
